FILE: design/gclnc_pkg.sv
// ----------------------------------------------------------------------------
// G-code line checker package
// Shared constants, status codes and the line record passed from the byte
// parser to the verdict stage.
// ----------------------------------------------------------------------------
package gclnc_pkg;

	localparam int LINE_CAPACITY = 64;
	localparam int LEN_W         = $clog2(LINE_CAPACITY + 2);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [31:0] NUM_SAT = 32'h8000_0000;
	localparam logic [31:0] NUM_MAX = 32'h7FFF_FFFF;
	localparam logic [15:0] CHK_SAT = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BLANK        = 3'd1,
		ST_WRONG_NUMBER = 3'd2,
		ST_MISSING_NUM  = 3'd3,
		ST_MISSING_CHK  = 3'd4,
		ST_CHK_MISMATCH = 3'd5,
		ST_OVERFLOW     = 3'd6
	} status_t;

	typedef struct packed {
		logic        blank;
		logic        overflow;
		logic        has_number;
		logic        star_seen;
		logic [31:0] number;
		logic [7:0]  computed;
		logic [15:0] received;
		logic [6:0]  length;
	} line_rec_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

FILE: design/gclnc_front.sv
// ----------------------------------------------------------------------------
// G-code line checker byte parser
// Takes one byte per word, tracks the running XOR, the checksum after the
// last star and the line number, and emits one line record per terminator.
// ----------------------------------------------------------------------------
module gclnc_front import gclnc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [7:0] rx_byte,
	input  logic      q_full,
	output logic      q_push,
	output line_rec_t q_data
);

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	logic [7:0]       rx_xor_q;
	logic [7:0]       star_xor_q;
	logic             star_seen_q;
	logic [LEN_W-1:0] star_pos_q;
	logic [15:0]      chk_q;
	logic             digits_ended_q;
	logic [LEN_W-1:0] len_q;
	logic             has_n_q;
	logic             semi_q;
	phase_t           phase_q;
	logic             neg_q;
	logic [31:0]      num_q;

	logic        accept;
	logic        is_term;
	logic [35:0] num_prod;
	logic [31:0] num_next;
	logic [19:0] chk_prod;
	logic [15:0] chk_next;
	logic [31:0] num_bits;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_term  = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign q_push   = accept && is_term;

	always_comb begin
		num_prod = ({4'd0, num_q} << 3) + ({4'd0, num_q} << 1) + {32'd0, rx_byte[3:0]};
		num_next = (num_prod > {4'd0, NUM_SAT}) ? NUM_SAT : num_prod[31:0];
		chk_prod = ({4'd0, chk_q} << 3) + ({4'd0, chk_q} << 1) + {16'd0, rx_byte[3:0]};
		chk_next = (chk_prod > {4'd0, CHK_SAT}) ? CHK_SAT : chk_prod[15:0];
		if (neg_q) begin
			num_bits = 32'd0 - num_q;
		end else begin
			num_bits = (num_q > NUM_MAX) ? NUM_MAX : num_q;
		end
	end

	always_comb begin
		q_data.blank      = (len_q == '0) || semi_q;
		q_data.overflow   = len_q > LEN_W'(LINE_CAPACITY);
		q_data.has_number = has_n_q;
		q_data.star_seen  = star_seen_q;
		q_data.number     = has_n_q ? num_bits : 32'd0;
		q_data.computed   = star_seen_q ? star_xor_q : rx_xor_q;
		q_data.received   = star_seen_q ? chk_q : 16'd0;
		q_data.length     = star_seen_q ? 7'(star_pos_q) : 7'(len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_xor_q       <= '0;
			star_xor_q     <= '0;
			star_seen_q    <= 1'b0;
			star_pos_q     <= '0;
			chk_q          <= '0;
			digits_ended_q <= 1'b0;
			len_q          <= '0;
			has_n_q        <= 1'b0;
			semi_q         <= 1'b0;
			phase_q        <= PH_BEFORE;
			neg_q          <= 1'b0;
			num_q          <= '0;
		end else if (accept) begin
			if (is_term) begin
				rx_xor_q       <= '0;
				star_xor_q     <= '0;
				star_seen_q    <= 1'b0;
				star_pos_q     <= '0;
				chk_q          <= '0;
				digits_ended_q <= 1'b0;
				len_q          <= '0;
				has_n_q        <= 1'b0;
				semi_q         <= 1'b0;
				phase_q        <= PH_BEFORE;
				neg_q          <= 1'b0;
				num_q          <= '0;
			end else if (len_q >= LEN_W'(LINE_CAPACITY)) begin
				len_q <= LEN_W'(LINE_CAPACITY + 1);
			end else begin
				if (len_q == '0) begin
					has_n_q <= (rx_byte == CH_N);
					semi_q  <= (rx_byte == CH_SEMI);
				end else if (has_n_q) begin
					unique case (phase_q)
						PH_BEFORE: begin
							if ((rx_byte == CH_MINUS) || (rx_byte == CH_PLUS)) begin
								neg_q   <= (rx_byte == CH_MINUS);
								phase_q <= PH_DIGITS;
							end else if (is_digit(rx_byte)) begin
								num_q   <= num_next;
								phase_q <= PH_DIGITS;
							end else if ((rx_byte != CH_SPACE) && (rx_byte != CH_TAB)) begin
								phase_q <= PH_DONE;
							end
						end
						PH_DIGITS: begin
							if (is_digit(rx_byte)) begin
								num_q <= num_next;
							end else begin
								phase_q <= PH_DONE;
							end
						end
						default: begin
						end
					endcase
				end

				if (rx_byte == CH_STAR) begin
					star_xor_q     <= rx_xor_q;
					star_seen_q    <= 1'b1;
					star_pos_q     <= len_q;
					chk_q          <= '0;
					digits_ended_q <= 1'b0;
				end else if (star_seen_q && !digits_ended_q) begin
					if (is_digit(rx_byte)) begin
						chk_q <= chk_next;
					end else begin
						digits_ended_q <= 1'b1;
					end
				end

				rx_xor_q <= rx_xor_q ^ rx_byte;
				len_q    <= len_q + 1'b1;
			end
		end
	end

endmodule

FILE: design/gclnc_queue.sv
// ----------------------------------------------------------------------------
// G-code line checker record queue
// Short first-in first-out queue of line records between the parser and
// the verdict stage.
// ----------------------------------------------------------------------------
module gclnc_queue import gclnc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  line_rec_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      valid,
	output line_rec_t data
);

	line_rec_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/gclnc_back.sv
// ----------------------------------------------------------------------------
// G-code line checker verdict stage
// Checks each line record against the expected line number, its checksum and
// the strict mode setting, and holds the verdict in the output register.
// ----------------------------------------------------------------------------
module gclnc_back import gclnc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_strict,
	input  logic        q_valid,
	input  line_rec_t   q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] line_number_seen,
	output logic [7:0]  computed_checksum,
	output logic [15:0] received_checksum,
	output logic [6:0]  payload_length
);

	logic        strict_q;
	logic [31:0] expected_q;
	logic        valid_q;
	status_t     status_q;
	logic [31:0] number_q;
	logic [7:0]  computed_q;
	logic [15:0] received_q;
	logic [6:0]  length_q;

	status_t verdict;
	logic    number_match;
	logic    bump;

	assign q_pop = q_valid && (!valid_q || out_ready);

	always_comb begin
		number_match = q_data.number == expected_q;
		bump         = 1'b0;
		verdict      = ST_OK;
		if (q_data.blank) begin
			verdict = ST_BLANK;
		end else if (q_data.overflow) begin
			verdict = ST_OVERFLOW;
		end else begin
			if (q_data.has_number) begin
				if (!number_match) begin
					verdict = ST_WRONG_NUMBER;
				end else begin
					bump = 1'b1;
				end
			end else if (strict_q) begin
				verdict = ST_MISSING_NUM;
			end
			if (verdict == ST_OK) begin
				if (strict_q && !q_data.star_seen) begin
					verdict = ST_MISSING_CHK;
				end else if (q_data.star_seen && ({8'd0, q_data.computed} != q_data.received)) begin
					verdict = ST_CHK_MISMATCH;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q   <= 1'b0;
			expected_q <= '0;
			valid_q    <= 1'b0;
			status_q   <= ST_OK;
			number_q   <= '0;
			computed_q <= '0;
			received_q <= '0;
			length_q   <= '0;
		end else begin
			if (cfg_write) begin
				strict_q <= cfg_strict;
			end
			if (q_pop) begin
				valid_q  <= 1'b1;
				status_q <= verdict;
				if (bump) begin
					expected_q <= expected_q + 32'd1;
				end
				if (q_data.blank || q_data.overflow) begin
					number_q   <= '0;
					computed_q <= '0;
					received_q <= '0;
					length_q   <= '0;
				end else begin
					number_q   <= q_data.number;
					computed_q <= q_data.computed;
					received_q <= q_data.received;
					length_q   <= q_data.length;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid         = valid_q;
	assign status            = status_q;
	assign line_number_seen  = number_q;
	assign computed_checksum = computed_q;
	assign received_checksum = received_q;
	assign payload_length    = length_q;

endmodule

FILE: design/gcode_line_number_checksum_check.sv
// ----------------------------------------------------------------------------
// G-code line number and checksum checker
// Parses a received byte stream and gives one verdict word per line end.
// ----------------------------------------------------------------------------
// The block takes one byte word per clock cycle while the record queue has
// room. Ordinary bytes are always taken while the two-entry record queue has
// room; a CR or LF byte pushes a line record into that queue, and the verdict
// stage turns it into a result word in the output register once the output
// side is free. The queue depth sets how many verdicts may wait on a stalled
// output before input stalls. The strict mode register is written through its
// own channel, which is always ready; the user must change it only while no
// line is in flight, which the block itself does not enforce.
module gcode_line_number_checksum_check import gclnc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               strict_mode,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] line_number_seen,
	output logic [7:0]         computed_checksum,
	output logic [15:0]        received_checksum,
	output logic [6:0]         payload_length
);

	logic        q_full;
	logic        q_push;
	line_rec_t   q_in;
	logic        q_pop;
	logic        q_valid;
	line_rec_t   q_out;
	logic [31:0] number;

	assign cfg_ready = 1'b1;

	gclnc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	gclnc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.data      (q_out)
	);

	gclnc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_valid && cfg_ready),
		.cfg_strict        (strict_mode),
		.q_valid           (q_valid),
		.q_data            (q_out),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.line_number_seen  (number),
		.computed_checksum (computed_checksum),
		.received_checksum (received_checksum),
		.payload_length    (payload_length)
	);

	assign line_number_seen = signed'(number);

endmodule

FILE: tb/tb_gcode_line_number_checksum_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// G-code line number and checksum checker testbench
// Feeds byte words through the input channel with random gaps and output
// stalls. A scoreboard predicts one verdict per line end and checks every
// field of each verdict word in order. Short directed lines cover blank,
// comment, numbered, mismatching and null-byte lines. Random well-formed and
// broken lines follow, under both settings of strict mode.
// ----------------------------------------------------------------------------
module tb_gcode_line_number_checksum_check;
	import gclnc_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 950;
	localparam int SEGMENTS     = 6;

	typedef enum logic [1:0] {
		NUM_LEAD,
		NUM_DIGITS,
		NUM_DONE
	} num_state_t;

	typedef struct {
		status_t     status;
		logic [31:0] number;
		logic [7:0]  computed;
		logic [15:0] received;
		logic [6:0]  length;
	} verdict_t;

	class line_scoreboard;
		logic        strict;
		logic [31:0] next_line;
		logic [7:0]  run_xor;
		logic [7:0]  star_xor;
		bit          star_seen;
		bit          digits_done;
		bit          is_n_line;
		bit          is_comment;
		bit          neg;
		logic [6:0]  star_pos;
		int unsigned len;
		logic [15:0] chk;
		num_state_t  num_state;
		logic [31:0] num_mag;
		verdict_t    expected_q[$];
		int          errors;

		function new();
			strict    = 1'b0;
			next_line = '0;
			errors    = 0;
			clear_line();
		endfunction

		function void clear_line();
			run_xor     = '0;
			star_xor    = '0;
			star_seen   = 1'b0;
			digits_done = 1'b0;
			is_n_line   = 1'b0;
			is_comment  = 1'b0;
			neg         = 1'b0;
			star_pos    = '0;
			len         = 0;
			chk         = '0;
			num_state   = NUM_LEAD;
			num_mag     = '0;
		endfunction

		function bit is_dec(logic [7:0] b);
			return (b >= CH_ZERO) && (b <= CH_NINE);
		endfunction

		function void add_digit(logic [7:0] b);
			logic [63:0] prod;
			prod = 64'(num_mag) * 64'd10 + 64'(b - CH_ZERO);
			num_mag = (prod > 64'(NUM_SAT)) ? NUM_SAT : prod[31:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_byte(logic [7:0] b);
			verdict_t    v;
			logic [31:0] num;
			int unsigned acc;
			if (b == CH_CR || b == CH_LF) begin
				v.status   = ST_OK;
				v.number   = '0;
				v.computed = '0;
				v.received = '0;
				v.length   = '0;
				if (len == 0 || is_comment) begin
					v.status = ST_BLANK;
				end else if (len > LINE_CAPACITY) begin
					v.status = ST_OVERFLOW;
				end else begin
					if (is_n_line) begin
						if (neg) begin
							num = 32'd0 - num_mag;
						end else begin
							num = (num_mag > NUM_MAX) ? NUM_MAX : num_mag;
						end
						v.number = num;
						if (num != next_line) begin
							v.status = ST_WRONG_NUMBER;
						end else begin
							next_line = next_line + 32'd1;
						end
					end else if (strict) begin
						v.status = ST_MISSING_NUM;
					end
					if (v.status == ST_OK) begin
						if (strict && !star_seen) begin
							v.status = ST_MISSING_CHK;
						end else if (star_seen && 16'(star_xor) != chk) begin
							v.status = ST_CHK_MISMATCH;
						end
					end
					v.computed = star_seen ? star_xor : run_xor;
					v.received = star_seen ? chk : 16'd0;
					v.length   = star_seen ? star_pos : 7'(len);
				end
				expected_q.push_back(v);
				clear_line();
				return;
			end
			if (len >= LINE_CAPACITY) begin
				len = LINE_CAPACITY + 1;
				return;
			end
			if (len == 0) begin
				is_n_line  = (b == CH_N);
				is_comment = (b == CH_SEMI);
			end else if (is_n_line) begin
				case (num_state)
					NUM_LEAD: begin
						if (b == CH_MINUS || b == CH_PLUS) begin
							neg       = (b == CH_MINUS);
							num_state = NUM_DIGITS;
						end else if (is_dec(b)) begin
							add_digit(b);
							num_state = NUM_DIGITS;
						end else if (b != CH_SPACE && b != CH_TAB) begin
							num_state = NUM_DONE;
						end
					end
					NUM_DIGITS: begin
						if (is_dec(b)) begin
							add_digit(b);
						end else begin
							num_state = NUM_DONE;
						end
					end
					default: ;
				endcase
			end
			if (b == CH_STAR) begin
				star_xor    = run_xor;
				star_seen   = 1'b1;
				star_pos    = 7'(len);
				chk         = '0;
				digits_done = 1'b0;
			end else if (star_seen && !digits_done) begin
				if (is_dec(b)) begin
					acc = int'(chk) * 10 + int'(b - CH_ZERO);
					chk = (acc > 32'hFFFF) ? CHK_SAT : acc[15:0];
				end else begin
					digits_done = 1'b1;
				end
			end
			run_xor = run_xor ^ b;
			len     = len + 1;
		endfunction

		function void check_result(logic [2:0] st, logic [31:0] num, logic [7:0] comp,
			logic [15:0] recv, logic [6:0] plen);
			verdict_t v;
			if (expected_q.size() == 0) begin
				$error("verdict word with none expected: status %0d", st);
				errors++;
				return;
			end
			v = expected_q.pop_front();
			if (st !== v.status) begin
				$error("status: expected %0d, got %0d", v.status, st);
				errors++;
			end
			if (num !== v.number) begin
				$error("line_number_seen: expected %0d, got %0d",
					$signed(v.number), $signed(num));
				errors++;
			end
			if (comp !== v.computed) begin
				$error("computed_checksum: expected %0d, got %0d", v.computed, comp);
				errors++;
			end
			if (recv !== v.received) begin
				$error("received_checksum: expected %0d, got %0d", v.received, recv);
				errors++;
			end
			if (plen !== v.length) begin
				$error("payload_length: expected %0d, got %0d", v.length, plen);
				errors++;
			end
		endfunction
	endclass

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_valid   = 1'b0;
	logic               cfg_ready;
	logic               strict_mode = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte     = 8'h00;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] line_number_seen;
	logic [7:0]         computed_checksum;
	logic [15:0]        received_checksum;
	logic [6:0]         payload_length;

	line_scoreboard sb;
	logic [7:0]     line_buf[$];
	string          body_chars   = "GMXYZEFS0123456789.- ";
	int             in_idle_pct  = 16;
	int             out_idle_pct = 83;
	int             quiet_cycles = 0;

	gcode_line_number_checksum_check dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.strict_mode       (strict_mode),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.line_number_seen  (line_number_seen),
		.computed_checksum (computed_checksum),
		.received_checksum (received_checksum),
		.payload_length    (payload_length)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(status, line_number_seen, computed_checksum,
				received_checksum, payload_length);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("gcode_line_number_checksum_check regression: fail");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	task automatic push_body(input int n);
		repeat (n) line_buf.push_back(body_chars[$urandom_range(body_chars.len() - 1)]);
	endtask

	task automatic write_strict(input logic v);
		cfg_valid   <= 1'b1;
		strict_mode <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.strict = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic build_line(output logic [7:0] term);
		int          kind;
		logic [31:0] want;
		logic [7:0]  x;
		line_buf.delete();
		term = $urandom_range(1) ? CH_LF : CH_CR;
		kind = $urandom_range(99);
		if (kind < 58) begin
			if ($urandom_range(9) != 0) begin
				push_text("N");
				if ($urandom_range(4) == 0) push_text($urandom_range(1) ? " " : "\t ");
				want = sb.next_line;
				case ($urandom_range(9))
					0: want = want + 32'd1;
					1: want = want - 32'd1;
					default: ;
				endcase
				if ($urandom_range(5) == 0) push_text("+");
				push_text($sformatf("%0d", want));
				if ($urandom_range(7) == 0) push_text(".7");
				push_text(" ");
			end
			push_body($urandom_range(12));
			if ($urandom_range(9) == 0) begin
				push_text("*");
				push_body($urandom_range(3));
			end
			if ($urandom_range(7) != 0) begin
				x = '0;
				foreach (line_buf[i]) x = x ^ line_buf[i];
				if ($urandom_range(7) == 0) x = x ^ 8'($urandom_range(1, 255));
				push_text("*");
				push_text($sformatf("%0d", x));
			end
		end else if (kind < 68) begin
			repeat ($urandom_range(1, 30)) begin
				do x = 8'($urandom_range(255)); while (x == CH_CR || x == CH_LF);
				line_buf.push_back(x);
			end
		end else if (kind < 76) begin
			if ($urandom_range(1)) begin
				push_text(";");
				push_body($urandom_range(10));
			end
		end else if (kind < 86) begin
			case ($urandom_range(6))
				0: push_text("N99999999999");
				1: push_text("N-99999999999");
				2: push_text("N-2147483648");
				3: push_text("N2147483647");
				4: push_text("N - 3");
				5: push_text("N");
				default: push_text("G0");
			endcase
			case ($urandom_range(4))
				0: push_text("*99999");
				1: push_text("*65535");
				2: push_text("*");
				3: push_text("*12x4");
				default: push_text(" X1");
			endcase
		end else if (kind < 92) begin
			if ($urandom_range(1)) push_text("N");
			push_body($urandom_range(LINE_CAPACITY - 2, LINE_CAPACITY + 12));
			if ($urandom_range(3) == 0) push_text("*1");
		end else begin
			push_text($urandom_range(1) ? "n" : "*");
			push_body($urandom_range(4));
			if ($urandom_range(1)) push_text("*0");
		end
	endtask

	initial begin
		logic [7:0] term;
		int         sent;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_strict(1'b0);
		send_byte(CH_LF);
		send_text(";");
		send_byte(CH_CR);
		send_text("N0*126");
		send_byte(CH_LF);
		send_text("N7");
		send_byte(CH_CR);
		send_text("G1");
		send_byte(CH_LF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("*9");
		send_byte(CH_LF);
		settle();
		write_strict(1'b1);
		send_text("G");
		send_byte(CH_LF);
		send_text("N1");
		send_byte(CH_CR);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			settle();
			case (seg / 2)
				0: begin
					in_idle_pct  = 16;
					out_idle_pct = 83;
				end
				1: begin
					in_idle_pct  = 83;
					out_idle_pct = 16;
				end
				default: begin
					in_idle_pct  = 0;
					out_idle_pct = 0;
				end
			endcase
			write_strict(1'(seg % 2));
			sent = 0;
			while (sent < RANDOM_BYTES / SEGMENTS) begin
				build_line(term);
				foreach (line_buf[i]) send_byte(line_buf[i]);
				send_byte(term);
				sent += line_buf.size() + 1;
			end
		end
		settle();

		if (sb.pending() != 0) begin
			$error("%0d verdict words never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("gcode_line_number_checksum_check regression: pass");
		end else begin
			$display("gcode_line_number_checksum_check regression: fail");
		end
		$finish;
	end

endmodule
